[hdl/idr_pkg.sv]
// ----------------------------------------------------------------------------
// idr_pkg
// Shared constants, register indexes and defaults for the delta reconstructor.
// ----------------------------------------------------------------------------
`default_nettype none

package idr_pkg;

    localparam int BYTE_W          = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 11;
    localparam int BPP_REG_W       = 3;
    localparam int RECENT_DEPTH    = 4;
    localparam int RECENT_IDX_W    = 2;

    localparam int DEF_MAX_WIDTH       = 1024;
    localparam int DEF_MAX_HEIGHT      = 1024;
    localparam int DEF_MAX_PIXEL_BYTES = 4;

    localparam logic [CFG_DATA_W-1:0] RST_ROW_WIDTH    = 11'd1024;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 11'd1024;
    localparam logic [BPP_REG_W-1:0]  RST_PIXEL_BYTES  = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_PIXEL_BYTES  = 2'd2,
        REG_UNUSED       = 2'd3
    } t_reg_idx;

endpackage

`default_nettype wire

[hdl/image_delta_reconstruct.sv]
// ----------------------------------------------------------------------------
// image_delta_reconstruct
// Byte-serial decoder for a two-dimensional sub/up delta filter.
// ----------------------------------------------------------------------------
// Takes one filtered byte per clock unless the output stalls, and returns one
// reconstructed byte per byte taken from its output register. The line buffer
// is read as a byte enters stage one and written back as it leaves; a read of
// the entry being written in that cycle takes the fresh value from the
// recent-byte register. The rate is set by the single read and single write
// port of the line buffer, one of each per cycle. It needs no clearing pass
// after reset. Configuration is written through its own channel, always ready;
// the user must write it only while no byte is in flight (unchecked).
`default_nettype none

module image_delta_reconstruct
    import idr_pkg::*;
#(
    parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
    parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [BYTE_W-1:0]     i_filtered_byte,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [BYTE_W-1:0]     o_pixel_byte,
    output logic                       o_frame_done
);

    localparam int LINE_DEPTH = MAX_WIDTH * MAX_PIXEL_BYTES;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int COL_W      = $clog2(LINE_DEPTH + 1);
    localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
    localparam int BPP_W      = $clog2(MAX_PIXEL_BYTES + 1);

    logic [COL_W-1:0]  stride;
    logic [ROW_W-1:0]  height;
    logic [BPP_W-1:0]  bpp;

    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;

    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s1_first_row;
    logic              r_s1_head;
    logic              r_s1_fwd;
    logic              r_s1_frame_end;
    logic [RECENT_IDX_W-1:0] r_s1_sub_sel;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_done;

    logic [BYTE_W-1:0] r_recent [RECENT_DEPTH];

    logic              in_acc;
    logic              s1_adv;
    logic              row_end;
    logic              frame_end;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] above;
    logic [BYTE_W-1:0] rd_data;
    logic [BYTE_W-1:0] y;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;

    idr_cfg_regs #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .COL_W           (COL_W),
        .ROW_W           (ROW_W),
        .BPP_W           (BPP_W)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_stride   (stride),
        .o_height   (height),
        .o_bpp      (bpp)
    );

    idr_line_ram #(
        .DEPTH  (LINE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (y),
        .i_rd_en   (in_acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_cfg_ready = 1'b1;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign rd_addr    = r_col[ADDR_W-1:0];

    always_comb begin
        row_end   = (COL_W'(r_col + COL_W'(1)) >= stride);
        frame_end = row_end && (ROW_W'(r_row + ROW_W'(1)) >= height);
        priority if (!row_end) begin
            n_col = COL_W'(r_col + COL_W'(1));
            n_row = r_row;
        end else if (frame_end) begin
            n_col = '0;
            n_row = '0;
        end else begin
            n_col = '0;
            n_row = ROW_W'(r_row + ROW_W'(1));
        end
    end

    always_comb begin
        above = r_s1_fwd ? r_recent[0] : rd_data;
        priority if (r_s1_first_row && r_s1_head) begin
            y = r_s1_byte;
        end else if (r_s1_first_row) begin
            y = r_s1_byte + r_recent[r_s1_sub_sel];
        end else begin
            y = r_s1_byte + above;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < RECENT_DEPTH; i++) begin
                r_recent[i] <= '0;
            end
        end else begin
            if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end

            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_recent[0] <= y;
                for (int i = 1; i < RECENT_DEPTH; i++) begin
                    r_recent[i] <= r_recent[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_byte      <= i_filtered_byte;
            r_s1_addr      <= rd_addr;
            r_s1_first_row <= (r_row == '0);
            r_s1_head      <= (r_col < COL_W'(bpp));
            r_s1_fwd       <= s1_adv && (r_s1_addr == rd_addr);
            r_s1_frame_end <= frame_end;
            r_s1_sub_sel   <= RECENT_IDX_W'(bpp - BPP_W'(1));
        end
        if (s1_adv) begin
            r_out_byte <= y;
            r_out_done <= r_s1_frame_end;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_byte = r_out_byte;
    assign o_frame_done = r_out_done;

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < COL_W'(LINE_DEPTH))
        else $error("column counter beyond line buffer");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && frame_end) |=> (r_row == '0 && r_col == '0))
        else $error("counters did not restart after frame end");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_addr)))
        else $error("stalled item lost from stage one");

    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted item not in stage one");

endmodule

`default_nettype wire

[hdl/idr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// idr_cfg_regs
// Configuration register file with range clamping and row stride.
// ----------------------------------------------------------------------------
`default_nettype none

module idr_cfg_regs
    import idr_pkg::*;
#(
    parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
    parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES,
    parameter int COL_W           = 13,
    parameter int ROW_W           = 11,
    parameter int BPP_W           = 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [CFG_DATA_W-1:0] i_wr_data,
    output logic      [COL_W-1:0]      o_stride,
    output logic      [ROW_W-1:0]      o_height,
    output logic      [BPP_W-1:0]      o_bpp
);

    localparam int WID_W = $clog2(MAX_WIDTH + 1);

    logic [CFG_DATA_W-1:0] r_row_width;
    logic [CFG_DATA_W-1:0] r_frame_height;
    logic [BPP_REG_W-1:0]  r_pixel_bytes;
    logic [WID_W-1:0]      width_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width    <= RST_ROW_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_pixel_bytes  <= RST_PIXEL_BYTES;
        end else if (i_wr_en) begin
            unique case (t_reg_idx'(i_wr_index))
                REG_ROW_WIDTH:    r_row_width    <= i_wr_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_wr_data;
                REG_PIXEL_BYTES:  r_pixel_bytes  <= i_wr_data[BPP_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_row_width == '0) begin
            width_c = WID_W'(1);
        end else if (r_row_width > MAX_WIDTH) begin
            width_c = WID_W'(MAX_WIDTH);
        end else begin
            width_c = WID_W'(r_row_width);
        end

        priority if (r_frame_height == '0) begin
            o_height = ROW_W'(1);
        end else if (r_frame_height > MAX_HEIGHT) begin
            o_height = ROW_W'(MAX_HEIGHT);
        end else begin
            o_height = ROW_W'(r_frame_height);
        end

        priority if (r_pixel_bytes == '0) begin
            o_bpp = BPP_W'(1);
        end else if (r_pixel_bytes > MAX_PIXEL_BYTES) begin
            o_bpp = BPP_W'(MAX_PIXEL_BYTES);
        end else begin
            o_bpp = BPP_W'(r_pixel_bytes);
        end
    end

    assign o_stride = COL_W'(width_c) * COL_W'(o_bpp);

endmodule

`default_nettype wire

[hdl/idr_line_ram.sv]
// ----------------------------------------------------------------------------
// idr_line_ram
// Single-port-write, single-port-read line buffer with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module idr_line_ram
    import idr_pkg::*;
#(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [BYTE_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire
